// File: hw/rtl/rcr_pkg.sv
// Shared constants, types and sequencer states of the raycast column renderer.
`timescale 1ns / 1ps
package rcr_pkg;

	// Screen and map geometry
	localparam int SCREEN_WIDTH  = 120;
	localparam int SCREEN_HEIGHT = 40;
	localparam int MAP_SIDE      = 16;
	localparam int MAX_STEPS     = 160;

	// Field widths
	localparam int COL_W   = 7;
	localparam int ROW_W   = 6;
	localparam int STEPS_W = 8;
	localparam int ANG_W   = 10;
	localparam int POSR_W  = 12;   // register position, Q4.8
	localparam int POS_W   = 23;   // march position, signed Q6.16 with headroom
	localparam int STEP_W  = 14;   // signed per-step move, Q.16
	localparam int CEIL_W  = 8;    // signed ceiling row
	localparam int MAP_BITS = 256;

	// Ray and march constants
	localparam int FOV_UNITS    = 128;
	localparam int STEP_MUL     = 6554;  // 0.1 cell in Q.16 per unit sine
	localparam int STEP_RND     = 8192;
	localparam int NEAR_TENTHS  = 20;    // distance 2.0 cells in tenths
	localparam int QUARTER_TURN = 256;
	localparam int HALF_TURN    = 512;

	// column * FOV_UNITS / SCREEN_WIDTH as (column * 4370) >> 12, exact for columns 0 to 127
	localparam int ANG_RECIP_MUL   = 4370;
	localparam int ANG_RECIP_SHIFT = 12;

	// Bhaskara sine: 16p/(5*512^2 - 4p), scaled to Q2.14
	localparam int SIN_DEN0  = 1310720;
	localparam int SIN_SHIFT = 18;       // 16 * 16384

	// Shared divider sizing
	localparam int DIV_NUM_W = 35;
	localparam int DIV_DEN_W = 21;
	localparam int DIV_QUO_W = 15;
	localparam int DIV_CNT_W = $clog2(DIV_QUO_W);

	// APB register map (byte address = 8 * index)
	localparam int APB_AW = 6;
	localparam int APB_DW = 64;
	localparam logic [2:0] REG_PLAYER_X     = 3'd0;
	localparam logic [2:0] REG_PLAYER_Y     = 3'd1;
	localparam logic [2:0] REG_PLAYER_ANGLE = 3'd2;
	localparam logic [2:0] REG_WALL_A       = 3'd3;
	localparam logic [2:0] REG_WALL_B       = 3'd4;
	localparam logic [2:0] REG_WALL_C       = 3'd5;
	localparam logic [2:0] REG_WALL_D       = 3'd6;

	// Reset map: open 7x14 room
	localparam logic [63:0] WALL_A_RST = 64'hF80F_F80F_F80F_FFFF;
	localparam logic [63:0] WALL_B_RST = 64'hF80F_F80F_F80F_F80F;
	localparam logic [63:0] WALL_C_RST = 64'hF80F_F80F_F80F_F80F;
	localparam logic [63:0] WALL_D_RST = 64'hFFFF_F80F_F80F_F80F;
	localparam logic [POSR_W-1:0] PLAYER_POS_RST = 12'd2048;

	typedef struct packed {
		logic [POSR_W-1:0]   player_x;
		logic [POSR_W-1:0]   player_y;
		logic [ANG_W-1:0]    player_angle;
		logic [MAP_BITS-1:0] walls;       // bit 16*y + x
	} cfg_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_QUO_W-1:0] quo;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ANG,
		ST_SIN_P,
		ST_SIN_GO,
		ST_SIN_DIV,
		ST_SIN_MUL,
		ST_MARCH,
		ST_CEIL_GO,
		ST_CEIL_DIV,
		ST_ROWS
	} state_t;

endpackage

// File: hw/rtl/rcr_regs.sv
// APB register file holding player pose and wall bitmap.
`timescale 1ns / 1ps
module rcr_regs import rcr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [POSR_W-1:0] player_x_q;
	logic [POSR_W-1:0] player_y_q;
	logic [ANG_W-1:0]  player_angle_q;
	logic [63:0]       wall_a_q;
	logic [63:0]       wall_b_q;
	logic [63:0]       wall_c_q;
	logic [63:0]       wall_d_q;
	logic [2:0]        idx;
	logic              wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[APB_AW-1:3];
	assign wr_en  = psel & penable & pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			player_x_q     <= PLAYER_POS_RST;
			player_y_q     <= PLAYER_POS_RST;
			player_angle_q <= '0;
			wall_a_q       <= WALL_A_RST;
			wall_b_q       <= WALL_B_RST;
			wall_c_q       <= WALL_C_RST;
			wall_d_q       <= WALL_D_RST;
		end else if (wr_en) begin
			case (idx)
				REG_PLAYER_X:     player_x_q     <= pwdata[POSR_W-1:0];
				REG_PLAYER_Y:     player_y_q     <= pwdata[POSR_W-1:0];
				REG_PLAYER_ANGLE: player_angle_q <= pwdata[ANG_W-1:0];
				REG_WALL_A:       wall_a_q       <= pwdata;
				REG_WALL_B:       wall_b_q       <= pwdata;
				REG_WALL_C:       wall_c_q       <= pwdata;
				REG_WALL_D:       wall_d_q       <= pwdata;
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			REG_PLAYER_X:     prdata = APB_DW'(player_x_q);
			REG_PLAYER_Y:     prdata = APB_DW'(player_y_q);
			REG_PLAYER_ANGLE: prdata = APB_DW'(player_angle_q);
			REG_WALL_A:       prdata = wall_a_q;
			REG_WALL_B:       prdata = wall_b_q;
			REG_WALL_C:       prdata = wall_c_q;
			REG_WALL_D:       prdata = wall_d_q;
			default:          prdata = '0;
		endcase
	end

	assign cfg.player_x     = player_x_q;
	assign cfg.player_y     = player_y_q;
	assign cfg.player_angle = player_angle_q;
	assign cfg.walls        = {wall_d_q, wall_c_q, wall_b_q, wall_a_q};

endmodule

// File: hw/rtl/rcr_div.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module rcr_div import rcr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_QUO_W-1:0] qn_q;     // numerator bits out, quotient bits in
	logic [DIV_DEN_W:0]   trial;
	logic                 ge;

	// quotient is known to fit DIV_QUO_W bits, so the top of num seeds the remainder
	assign trial = {rem_q, qn_q[DIV_QUO_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_QUO_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= DIV_DEN_W'(req.num[DIV_NUM_W-1:DIV_QUO_W]);
			qn_q  <= req.num[DIV_QUO_W-1:0];
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
			qn_q  <= {qn_q[DIV_QUO_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = qn_q;

endmodule

// File: hw/rtl/raycast_column_renderer_core.sv
// Top level: column sequencer, ray march and row output of the raycaster.
`timescale 1ns / 1ps
// One request on s_* names a screen column; the block answers with SCREEN_HEIGHT
// requests on m_*, one per screen row from the top, the final one with tlast.
// A column first takes its ray angle and the two sine values, each sine a pass
// through the shared one-bit-per-cycle divider, then one march step per cycle
// (1 to MAX_STEPS, set by where the ray meets a wall or leaves the map), then a
// divider pass for the ceiling row, then one row per cycle while m_tready is
// high; the block then returns to idle, where the next column is taken. s_tready
// is high only between columns.
// Registers sit at byte address 8*i on the APB port and may be written between
// columns.
module raycast_column_renderer_core import rcr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [6:0] column
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata,   // [6:0] column_out, [12:7] row, [13] is_wall,
	                                     // [21:14] hit_steps
	output logic              m_tlast,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	cfg_t     cfg;
	div_req_t div_req;
	div_rsp_t div_rsp;
	state_t   state_q, state_d;

	logic [COL_W-1:0]          column_q;
	logic [ANG_W-1:0]          angle_q;
	logic                      phase_q;    // 0: x move (sine), 1: y move (cosine)
	logic [16:0]               p_q;
	logic [DIV_QUO_W-1:0]      v_q;
	logic signed [STEP_W-1:0]  dx_q, dy_q;
	logic signed [POS_W-1:0]   px_q, py_q;
	logic [STEPS_W-1:0]        k_q;
	logic [STEPS_W-1:0]        steps_q;
	logic signed [CEIL_W-1:0]  ceil_q;
	logic [ROW_W-1:0]          row_q;

	logic [19:0]               ang_prod;
	logic [7:0]                ang_ofs;
	logic [ANG_W-1:0]          sin_ang;
	logic [8:0]                h;
	logic [9:0]                h_c;
	logic [20:0]               sin_den;
	logic [27:0]               step_prod;
	logic [STEP_W-1:0]         step_mag;
	logic signed [STEP_W-1:0]  step_val;
	logic signed [POS_W-1:0]   nx, ny;
	logic                      out_map;
	logic                      wall_hit;
	logic                      march_end;
	logic [STEPS_W-1:0]        kd;
	logic signed [CEIL_W-1:0]  row_s;
	logic signed [CEIL_W-1:0]  floor_s;
	logic                      is_wall;
	logic                      last_row;

	rcr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rcr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// column offset within the field of view: column * 128 / 120
	assign ang_prod = 20'(column_q) * 20'(ANG_RECIP_MUL);
	assign ang_ofs  = ang_prod[19:ANG_RECIP_SHIFT];

	// sine argument and Bhaskara terms
	assign sin_ang = phase_q ? angle_q + ANG_W'(QUARTER_TURN) : angle_q;
	assign h       = sin_ang[8:0];
	assign h_c     = 10'(HALF_TURN) - {1'b0, h};
	assign sin_den = 21'(SIN_DEN0) - {p_q, 2'b00};

	// per-step move: round(|s| * 6554 / 2^14), signed
	assign step_prod = 28'(v_q) * 28'(STEP_MUL) + 28'(STEP_RND);
	assign step_mag  = step_prod[27:14];
	assign step_val  = sin_ang[ANG_W-1] ? -$signed(step_mag) : $signed(step_mag);

	// march step: advance, then test map bounds and wall bit
	assign nx        = px_q + POS_W'(dx_q);
	assign ny        = py_q + POS_W'(dy_q);
	assign out_map   = nx[POS_W-1] || ny[POS_W-1] ||
	                   (nx[POS_W-2:16] >= 6'(MAP_SIDE)) || (ny[POS_W-2:16] >= 6'(MAP_SIDE));
	assign wall_hit  = cfg.walls[{ny[19:16], nx[19:16]}];
	assign march_end = out_map || wall_hit || (k_q == STEPS_W'(MAX_STEPS));

	// ceiling numerator term |k - 20|
	assign kd = (steps_q >= STEPS_W'(NEAR_TENTHS)) ? steps_q - STEPS_W'(NEAR_TENTHS)
	                                               : STEPS_W'(NEAR_TENTHS) - steps_q;

	// row classification
	assign row_s    = CEIL_W'({2'b00, row_q});
	assign floor_s  = CEIL_W'(SCREEN_HEIGHT) - ceil_q;
	assign is_wall  = (row_s > ceil_q) && (row_s <= floor_s);
	assign last_row = row_q == ROW_W'(SCREEN_HEIGHT - 1);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (s_tvalid) state_d = ST_ANG;
			ST_ANG:      state_d = ST_SIN_P;
			ST_SIN_P:    state_d = ST_SIN_GO;
			ST_SIN_GO:   state_d = ST_SIN_DIV;
			ST_SIN_DIV:  if (div_rsp.done) state_d = ST_SIN_MUL;
			ST_SIN_MUL:  state_d = phase_q ? ST_MARCH : ST_SIN_P;
			ST_MARCH:    if (march_end) state_d = ST_CEIL_GO;
			ST_CEIL_GO:  state_d = ST_CEIL_DIV;
			ST_CEIL_DIV: if (div_rsp.done) state_d = ST_ROWS;
			ST_ROWS:     if (m_tready && last_row) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// outputs and divider requests
	always_comb begin
		s_tready      = 1'b0;
		m_tvalid      = 1'b0;
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_SIN_GO: begin
				div_req.start = 1'b1;
				div_req.num   = (DIV_NUM_W'(p_q) << SIN_SHIFT) + DIV_NUM_W'(sin_den[20:1]);
				div_req.den   = sin_den;
			end
			ST_CEIL_GO: begin
				div_req.start = 1'b1;
				div_req.num   = DIV_NUM_W'(kd) * DIV_NUM_W'(SCREEN_HEIGHT);
				div_req.den   = DIV_DEN_W'({steps_q, 1'b0});
			end
			ST_ROWS: begin
				m_tvalid = 1'b1;
			end
			default: ;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					column_q <= s_tdata[COL_W-1:0];
					phase_q  <= 1'b0;
					px_q     <= POS_W'({cfg.player_x, 8'h00});
					py_q     <= POS_W'({cfg.player_y, 8'h00});
					k_q      <= STEPS_W'(1);
				end
			end
			ST_ANG: begin
				angle_q <= cfg.player_angle - ANG_W'(FOV_UNITS / 2) + ANG_W'(ang_ofs);
			end
			ST_SIN_P: begin
				p_q <= 17'(h) * 17'(h_c);
			end
			ST_SIN_DIV: begin
				if (div_rsp.done) v_q <= div_rsp.quo;
			end
			ST_SIN_MUL: begin
				if (phase_q) begin
					dy_q <= step_val;
				end else begin
					dx_q <= step_val;
				end
				phase_q <= 1'b1;
			end
			ST_MARCH: begin
				px_q <= nx;
				py_q <= ny;
				k_q  <= k_q + 1'b1;
				if (march_end) begin
					steps_q <= (!out_map && wall_hit) ? k_q : STEPS_W'(MAX_STEPS);
				end
			end
			ST_CEIL_GO: begin
				row_q <= '0;
			end
			ST_CEIL_DIV: begin
				if (div_rsp.done) begin
					// near walls: negative ceiling clamps at -1
					if (steps_q >= STEPS_W'(NEAR_TENTHS)) begin
						ceil_q <= CEIL_W'(div_rsp.quo[CEIL_W-2:0]);
					end else begin
						ceil_q <= (div_rsp.quo != '0) ? -CEIL_W'(1) : '0;
					end
				end
			end
			ST_ROWS: begin
				if (m_tready) row_q <= row_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign m_tdata = {2'b00, steps_q, is_wall, row_q, column_q};
	assign m_tlast = last_row;

endmodule

// File: test/tb_raycast_column_renderer_core.sv
// Testbench of the raycast column renderer: column requests checked row by row against a predictor.
`timescale 1ns / 1ps
module tb_raycast_column_renderer_core;
	import rcr_pkg::*;

	localparam int STALL_LIMIT   = 4000;
	localparam int TAIL_CYCLES   = 300;
	localparam int RAND_SETUPS   = 10;
	localparam int COLS_PER_SET  = 45;
	localparam int DIR_COUNT     = 20;
	localparam int MAX_PRINTS    = 40;

	// Map styles of the random part
	typedef enum logic [1:0] {MAP_DENSE, MAP_SPARSE, MAP_ROOM} map_style_t;

	// Register setups of the directed part
	typedef enum logic [2:0] {
		DP_RESET_ROOM,
		DP_SOLID,
		DP_OPEN,
		DP_NEAR_ORIGIN,
		DP_FAR_CORNER
	} dir_setup_t;

	typedef struct packed {
		dir_setup_t  setup;
		logic [6:0]  column;
		logic        known;     // expected row pattern typed in below
		logic [7:0]  steps;
		int          ceiling;
	} dir_row_t;

	typedef struct packed {
		logic [COL_W-1:0]   column;
		logic [ROW_W-1:0]   row;
		logic               is_wall;
		logic [STEPS_W-1:0] steps;
		logic               last;
	} pixel_t;

	// Directed stimulus: reset room, solid map (hit on the first step, every row wall),
	// open map (ray leaves the map, steps MAX_STEPS), map corners, columns past the screen
	dir_row_t dir_rows [DIR_COUNT] = '{
		'{DP_RESET_ROOM,  7'd0,   1'b0, 8'd0,   0},
		'{DP_RESET_ROOM,  7'd60,  1'b1, 8'd70,  14},
		'{DP_RESET_ROOM,  7'd119, 1'b0, 8'd0,   0},
		'{DP_RESET_ROOM,  7'd127, 1'b0, 8'd0,   0},
		'{DP_RESET_ROOM,  7'd37,  1'b0, 8'd0,   0},
		'{DP_SOLID,       7'd0,   1'b1, 8'd1,   -1},
		'{DP_SOLID,       7'd127, 1'b1, 8'd1,   -1},
		'{DP_SOLID,       7'd64,  1'b1, 8'd1,   -1},
		'{DP_OPEN,        7'd0,   1'b1, 8'd160, 17},
		'{DP_OPEN,        7'd119, 1'b1, 8'd160, 17},
		'{DP_OPEN,        7'd90,  1'b1, 8'd160, 17},
		'{DP_NEAR_ORIGIN, 7'd0,   1'b0, 8'd0,   0},
		'{DP_NEAR_ORIGIN, 7'd60,  1'b0, 8'd0,   0},
		'{DP_NEAR_ORIGIN, 7'd127, 1'b0, 8'd0,   0},
		'{DP_NEAR_ORIGIN, 7'd100, 1'b0, 8'd0,   0},
		'{DP_FAR_CORNER,  7'd0,   1'b0, 8'd0,   0},
		'{DP_FAR_CORNER,  7'd30,  1'b0, 8'd0,   0},
		'{DP_FAR_CORNER,  7'd60,  1'b0, 8'd0,   0},
		'{DP_FAR_CORNER,  7'd119, 1'b0, 8'd0,   0},
		'{DP_FAR_CORNER,  7'd127, 1'b0, 8'd0,   0}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata = '0;   // [6:0] column
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [23:0]       m_tdata;        // [6:0] column_out, [12:7] row, [13] is_wall,
	                                   // [21:14] hit_steps
	logic              m_tlast;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	// Predictor copy of the registers
	logic [POSR_W-1:0]   view_x = PLAYER_POS_RST;
	logic [POSR_W-1:0]   view_y = PLAYER_POS_RST;
	logic [ANG_W-1:0]    view_angle = '0;
	logic [MAP_BITS-1:0] wall_map = {WALL_D_RST, WALL_C_RST, WALL_B_RST, WALL_A_RST};

	pixel_t expected_pixels [$];
	int     mismatches = 0;
	int     columns_sent = 0;
	int     rows_checked = 0;
	int     reg_writes = 0;
	int     setups_done = 0;
	int     idle_cycles = 0;
	bit     steady_flow = 1'b0;

	raycast_column_renderer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Bhaskara sine in Q2.14, negated on the second half turn
	function automatic int bhaskara_sine(input logic [ANG_W-1:0] a);
		longint h, p, den, v;
		h = longint'(a[8:0]);
		p = h * (HALF_TURN - h);
		den = SIN_DEN0 - 4 * p;
		v = ((longint'(1) << SIN_SHIFT) * p + den / 2) / den;
		return a[9] ? -int'(v) : int'(v);
	endfunction

	// Tenth of a cell along one axis, Q.16, sign kept
	function automatic longint tenth_cell_move(input int s);
		int     m;
		longint d;
		m = (s < 0) ? -s : s;
		d = (longint'(m) * STEP_MUL + STEP_RND) >>> 14;
		return (s < 0) ? -d : d;
	endfunction

	// Steps to the first wall cell; leaving the map or no hit gives MAX_STEPS
	function automatic int ray_steps(input logic [ANG_W-1:0] ang);
		longint dx, dy, px, py, cx, cy;
		int     k;
		dx = tenth_cell_move(bhaskara_sine(ang));
		dy = tenth_cell_move(bhaskara_sine(ang + ANG_W'(QUARTER_TURN)));
		for (k = 1; k <= MAX_STEPS; k++) begin
			px = (longint'(view_x) <<< 8) + k * dx;
			py = (longint'(view_y) <<< 8) + k * dy;
			if (px < 0 || py < 0)
				return MAX_STEPS;
			cx = px >>> 16;
			cy = py >>> 16;
			if (cx >= MAP_SIDE || cy >= MAP_SIDE)
				return MAX_STEPS;
			if (wall_map[int'(cy) * MAP_SIDE + int'(cx)])
				return k;
		end
		return MAX_STEPS;
	endfunction

	// Ceiling row from distance in tenths, clamped at -1 for very near walls
	function automatic int ceiling_row(input int steps);
		int c;
		if (steps >= NEAR_TENTHS)
			c = (SCREEN_HEIGHT * (steps - NEAR_TENTHS)) / (2 * steps);
		else
			c = -((SCREEN_HEIGHT * (NEAR_TENTHS - steps)) / (2 * steps));
		if (c < -1)
			c = -1;
		return c;
	endfunction

	task automatic queue_column(input logic [6:0] col, input int steps, input int ceiling);
		pixel_t px;
		int     y;
		for (y = 0; y < SCREEN_HEIGHT; y++) begin
			px.column = col;
			px.row = ROW_W'(y);
			px.is_wall = (y > ceiling) && (y <= SCREEN_HEIGHT - ceiling);
			px.steps = STEPS_W'(steps);
			px.last = (y == SCREEN_HEIGHT - 1);
			expected_pixels.push_back(px);
		end
	endtask

	task automatic predict_column(input logic [6:0] col);
		int           a;
		int           steps;
		logic [ANG_W-1:0] ang;
		a = int'(view_angle) + 1024 - FOV_UNITS / 2 + (int'(col) * FOV_UNITS) / SCREEN_WIDTH;
		ang = ANG_W'(a);
		steps = ray_steps(ang);
		queue_column(col, steps, ceiling_row(steps));
	endtask

	task automatic report_mismatch(input string field, input logic [6:0] col,
		input logic [5:0] row, input longint got, input longint want);
		if (mismatches < MAX_PRINTS)
			$display("ERROR %0t: column %0d row %0d %s got %0d want %0d",
				$realtime, col, row, field, got, want);
		mismatches++;
	endtask

	// Register write: setup cycle, access cycle, then the bus is released
	task automatic write_register(input logic [2:0] idx, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_PLAYER_X:     view_x = value[POSR_W-1:0];
			REG_PLAYER_Y:     view_y = value[POSR_W-1:0];
			REG_PLAYER_ANGLE: view_angle = value[ANG_W-1:0];
			REG_WALL_A:       wall_map[63:0] = value;
			REG_WALL_B:       wall_map[127:64] = value;
			REG_WALL_C:       wall_map[191:128] = value;
			REG_WALL_D:       wall_map[255:192] = value;
			default: ;
		endcase
		reg_writes++;
		@(posedge clk);
	endtask

	task automatic write_view(input logic [11:0] x, input logic [11:0] y,
		input logic [9:0] ang, input logic [255:0] walls);
		write_register(REG_PLAYER_X, 64'(x));
		write_register(REG_PLAYER_Y, 64'(y));
		write_register(REG_PLAYER_ANGLE, 64'(ang));
		write_register(REG_WALL_A, walls[63:0]);
		write_register(REG_WALL_B, walls[127:64]);
		write_register(REG_WALL_C, walls[191:128]);
		write_register(REG_WALL_D, walls[255:192]);
		setups_done++;
	endtask

	// One column request, with a random hold-off before it outside steady flow
	task automatic send_column(input logic [6:0] col);
		int gap;
		gap = steady_flow ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, col};
		do @(posedge clk); while (!s_tready);
		columns_sent++;
	endtask

	// Sender holds off until every expected row has come back
	task automatic wait_for_idle();
		s_tvalid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [255:0] random_map(input map_style_t style);
		logic [255:0] m;
		int           i;
		for (i = 0; i < 256; i++) begin
			case (style)
				MAP_DENSE:  m[i] = ($urandom_range(0, 2) == 0);
				MAP_SPARSE: m[i] = ($urandom_range(0, 15) == 0);
				default: begin
					// walled room with scattered pillars
					if (i % 16 == 0 || i % 16 == 15 || i < 16 || i >= 240)
						m[i] = 1'b1;
					else
						m[i] = ($urandom_range(0, 9) == 0);
				end
			endcase
		end
		return m;
	endfunction

	// Result side: random stall per row outside steady flow, check against the oldest expectation
	initial begin
		int     stall;
		pixel_t want;
		@(posedge arst_n);
		forever begin
			stall = steady_flow ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			rows_checked++;
			if (expected_pixels.size() == 0) begin
				report_mismatch("unexpected row", m_tdata[6:0], m_tdata[12:7], 1, 0);
			end else begin
				want = expected_pixels.pop_front();
				if (m_tdata[6:0] !== want.column)
					report_mismatch("column_out", want.column, want.row,
						m_tdata[6:0], want.column);
				if (m_tdata[12:7] !== want.row)
					report_mismatch("row", want.column, want.row, m_tdata[12:7], want.row);
				if (m_tdata[13] !== want.is_wall)
					report_mismatch("is_wall", want.column, want.row,
						m_tdata[13], want.is_wall);
				if (m_tdata[21:14] !== want.steps)
					report_mismatch("hit_steps", want.column, want.row,
						m_tdata[21:14], want.steps);
				if (m_tlast !== want.last)
					report_mismatch("tlast", want.column, want.row, m_tlast, want.last);
				if (m_tdata[23:22] !== 2'b00)
					report_mismatch("tdata pad", want.column, want.row, m_tdata[23:22], 0);
			end
		end
	end

	// Watchdog on cycles without any accepted request
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		int           i;
		int           p;
		int           j;
		logic [6:0]   col;
		logic [11:0]  x;
		logic [11:0]  y;
		map_style_t   style;
		logic [255:0] walls;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed table
		for (i = 0; i < DIR_COUNT; i++) begin
			if (i > 0 && dir_rows[i].setup != dir_rows[i - 1].setup) begin
				wait_for_idle();
				case (dir_rows[i].setup)
					DP_SOLID:       write_view(PLAYER_POS_RST, PLAYER_POS_RST, 10'd0, '1);
					DP_OPEN:        write_view(PLAYER_POS_RST, PLAYER_POS_RST, 10'd1023, '0);
					DP_NEAR_ORIGIN: write_view(12'd0, 12'd0, 10'd0,
						{WALL_D_RST, WALL_C_RST, WALL_B_RST, WALL_A_RST});
					DP_FAR_CORNER:  write_view(12'd4095, 12'd4095, 10'(HALF_TURN),
						{64'h0123_4567_89AB_CDEF, 64'h8000_0001_0000_0000,
						 64'hF0F0_0F0F_1111_8888, 64'h0000_0000_0000_0000});
					default: ;
				endcase
			end
			send_column(dir_rows[i].column);
			if (dir_rows[i].known)
				queue_column(dir_rows[i].column, int'(dir_rows[i].steps), dir_rows[i].ceiling);
			else
				predict_column(dir_rows[i].column);
		end

		// Random setups, a few with no stalls on either side
		for (p = 0; p < RAND_SETUPS; p++) begin
			wait_for_idle();
			style = map_style_t'(p % 3);
			walls = random_map(style);
			if (style == MAP_ROOM) begin
				x = 12'($urandom_range(256, 3839));
				y = 12'($urandom_range(256, 3839));
			end else begin
				x = 12'($urandom_range(0, 4095));
				y = 12'($urandom_range(0, 4095));
			end
			write_view(x, y, 10'($urandom_range(0, 1023)), walls);
			steady_flow = (p == 3 || p == 7);
			for (j = 0; j < COLS_PER_SET; j++) begin
				if ($urandom_range(0, 9) == 0)
					col = 7'($urandom_range(SCREEN_WIDTH, 127));
				else
					col = 7'($urandom_range(0, SCREEN_WIDTH - 1));
				send_column(col);
				predict_column(col);
			end
		end
		steady_flow = 1'b0;

		wait_for_idle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("tb: %0d columns cast over %0d register setups (%0d writes), %0d rows checked",
			columns_sent, setups_done, reg_writes, rows_checked);
		$display("tb: covered solid, open, room and random maps, corners and off-screen columns");
		if (mismatches == 0 && expected_pixels.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
